@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the stable priority queue
// Entry payload and the per-cycle command broadcast to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned PRI_W  = 8;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef struct packed {
		logic [PRI_W-1:0]  pri;
		logic [WORD_W-1:0] arr;
		logic [WORD_W-1:0] svc;
	} entry_t;

	// command seen by all cells in the same cycle
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t ent;
	} cmd_t;

endpackage

@@ hw/rtl/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue, oldest-first among equals
// Latency: one beat in, its result beat registered on the next cycle.
// Throughput: one beat per cycle; the cell chain re-sorts in a single step.
// Input is held off only while the result register is full and stalled.
// Reset (arst_n low): queue empty, no result pending; cell payloads unset.
// ----------------------------------------------------------------------------
module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic [WORD_W-1:0]                    arrival_word,
	input  logic [WORD_W-1:0]                    service_word,
	input  logic [PRI_W-1:0]                     priority_req,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 pop_valid,
	output logic [WORD_W-1:0]                    out_arrival,
	output logic [WORD_W-1:0]                    out_service,
	output logic [PRI_W-1:0]                     out_priority,
	output logic                                 push_dropped,
	output logic                                 is_empty,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]     occupancy
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	// The queue is a row of cells kept sorted by priority, highest at cell 0.
	// A push lands right after the last cell whose priority is >= the new one,
	// everything behind it shifts one cell right. A pop takes cell 0 and the
	// whole row shifts one cell left.

	logic             accept;
	logic             full;
	logic             empty;
	logic             push_ok;
	logic             pop_ok;
	logic             drop;
	cmd_t             cmd;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;

	logic   cell_vld  [QUEUE_DEPTH];
	entry_t cell_ent  [QUEUE_DEPTH];
	logic   cell_keep [QUEUE_DEPTH];

	// result register
	logic             res_vld_q;
	logic             pop_valid_q;
	entry_t           res_ent_q;
	logic             dropped_q;
	logic [CNT_W-1:0] occ_q;

	// a new beat goes in whenever the result slot is free or being drained
	assign in_stall = res_vld_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign push_ok = accept && (kind == KIND_PUSH) && !full;
	assign pop_ok  = accept && (kind == KIND_POP) && !empty;
	assign drop    = accept && (kind == KIND_PUSH) && full;

	assign cmd.push    = push_ok;
	assign cmd.pop     = pop_ok;
	assign cmd.ent.pri = priority_req;
	assign cmd.ent.arr = arrival_word;
	assign cmd.ent.svc = service_word;

	always_comb begin
		count_nxt = count_q;
		if (push_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (pop_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// cell chain
	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic   l_vld;
			entry_t l_ent;
			logic   l_keep;
			logic   r_vld;
			entry_t r_ent;

			if (gi == 0) begin : g_head
				// head: nothing ahead, so a push that beats it lands here
				assign l_vld  = 1'b0;
				assign l_ent  = '0;
				assign l_keep = 1'b1;
			end else begin : g_mid_l
				assign l_vld  = cell_vld[gi-1];
				assign l_ent  = cell_ent[gi-1];
				assign l_keep = cell_keep[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign r_vld = 1'b0;
				assign r_ent = '0;
			end else begin : g_mid_r
				assign r_vld = cell_vld[gi+1];
				assign r_ent = cell_ent[gi+1];
			end

			spq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.left_vld  (l_vld),
				.left_ent  (l_ent),
				.left_keep (l_keep),
				.right_vld (r_vld),
				.right_ent (r_ent),
				.vld       (cell_vld[gi]),
				.ent       (cell_ent[gi]),
				.keep      (cell_keep[gi])
			);
		end
	endgenerate

	// result beat; payload zero unless a pop returned an entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (accept) begin
			res_vld_q <= 1'b1;
		end else if (!out_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_valid_q <= pop_ok;
			res_ent_q   <= pop_ok ? cell_ent[0] : '0;
			dropped_q   <= drop;
			occ_q       <= count_nxt;
		end
	end

	assign out_valid    = res_vld_q;
	assign pop_valid    = pop_valid_q;
	assign out_arrival  = res_ent_q.arr;
	assign out_service  = res_ent_q.svc;
	assign out_priority = res_ent_q.pri;
	assign push_dropped = dropped_q;
	assign occupancy    = occ_q;
	assign is_empty     = (occ_q == '0);

endmodule

@@ hw/rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; shifts right on an insert at or ahead of it, left on pop.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  logic   left_vld,
	input  entry_t left_ent,
	input  logic   left_keep,
	input  logic   right_vld,
	input  entry_t right_ent,
	output logic   vld,
	output entry_t ent,
	output logic   keep
);

	logic   vld_q;
	entry_t ent_q;

	// stays put on insert: priority not below the new one (ties stay ahead)
	assign keep = vld_q && (ent_q.pri >= cmd.ent.pri);
	assign vld  = vld_q;
	assign ent  = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.push && !keep) begin
			vld_q <= left_keep ? 1'b1 : left_vld;
		end else if (cmd.pop) begin
			vld_q <= right_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !keep) begin
			ent_q <= left_keep ? cmd.ent : left_ent;
		end else if (cmd.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

@@ hw/rtl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the stable priority queue
// Watches result beats and the output handshake only.
// ----------------------------------------------------------------------------
module spq_checker
	import spq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 64
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             pop_valid,
	input logic [WORD_W-1:0]                out_arrival,
	input logic [WORD_W-1:0]                out_service,
	input logic [PRI_W-1:0]                 out_priority,
	input logic                             push_dropped,
	input logic                             is_empty,
	input logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);

	// a beat cannot both return an entry and report a dropped push
	a_pop_not_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pop_valid |-> !push_dropped)
		else $error("pop result also flags a dropped push");

	// no entry returned means all payload fields are zero
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pop_valid |-> (out_arrival == '0) && (out_service == '0)
			&& (out_priority == '0))
		else $error("payload not zero on a beat without an entry");

	// empty flag agrees with the fill level
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (occupancy == '0)))
		else $error("is_empty disagrees with occupancy");

	// a dropped push only happens at a full queue, which stays full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && push_dropped |-> (occupancy == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
		else $error("push dropped while queue not full");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pop_valid)
			&& $stable(out_arrival) && $stable(occupancy))
		else $error("stalled result beat changed");

endmodule

bind stable_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);
